// ===== rtl/gema_pkg.sv =====
// ----------------------------------------------------------------------------
// gema_pkg
// shared widths, types and codes of the greedy edge to matching assigner
// ----------------------------------------------------------------------------
package gema_pkg;

    localparam int MAX_VERTICES = 64;
    localparam int MAX_STAGES   = 64;

    localparam int VIN_W      = 7;   // input vertex field
    localparam int VCNT_W     = 7;   // vertex_count / stage_count registers
    localparam int VTX_W      = 6;   // vertex address into the stores
    localparam int STG_W      = 6;   // stage index
    localparam int FILL_W     = 6;   // pairs in one stage, up to 32
    localparam int SLOT_W     = 5;
    localparam int TOTAL_W    = 12;
    localparam int STATUS_W   = 3;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 7;

    typedef logic [MAX_STAGES-1:0]   t_mask;
    typedef logic [MAX_VERTICES-1:0] t_row;
    typedef logic [FILL_W-1:0]       t_fill;

    typedef enum logic [STATUS_W-1:0] {
        ST_PLACED     = 3'd0,
        ST_BAD_VERTEX = 3'd1,
        ST_REPEAT     = 3'd2,
        ST_NO_STAGE   = 3'd3,
        ST_STAGE_FULL = 3'd4,
        ST_JOB_DONE   = 3'd5,
        ST_BAD_CONFIG = 3'd6
    } t_status;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_VERTEX_COUNT = 1'b0,
        CFG_STAGE_COUNT  = 1'b1
    } t_cfg_reg;

    typedef struct packed {
        logic [STG_W-1:0] idx;
        t_fill            cnt;
    } t_pick;

endpackage

// ===== rtl/gema_mask_mem.sv =====
// ----------------------------------------------------------------------------
// gema_mask_mem
// per-vertex stage mask store: one write port, two registered read ports,
// row valid bits for instant clear, write-to-read bypass on the load edge
// ----------------------------------------------------------------------------
module gema_mask_mem (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_clr,
    input  logic                      i_we,
    input  logic [gema_pkg::VTX_W-1:0] i_waddr,
    input  gema_pkg::t_mask           i_wdata,
    input  logic                      i_re,
    input  logic [gema_pkg::VTX_W-1:0] i_raddr0,
    input  logic [gema_pkg::VTX_W-1:0] i_raddr1,
    output gema_pkg::t_mask           o_rdata0,
    output gema_pkg::t_mask           o_rdata1
);
    import gema_pkg::*;

    t_mask                   r_mem [MAX_VERTICES];
    logic [MAX_VERTICES-1:0] r_vld;
    t_mask                   r_raw0;
    t_mask                   r_raw1;
    t_mask                   r_byp;
    logic                    r_zero0;
    logic                    r_zero1;
    logic                    r_use_byp0;
    logic                    r_use_byp1;
    logic                    hit0;
    logic                    hit1;

    assign hit0 = i_we && (i_waddr == i_raddr0);
    assign hit1 = i_we && (i_waddr == i_raddr1);

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_raw0 <= r_mem[i_raddr0];
            r_raw1 <= r_mem[i_raddr1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_clr) begin
            r_vld <= '0;
        end else if (i_we) begin
            r_vld[i_waddr] <= 1'b1;
        end
    end

    // select flags taken with the read so a held read stays consistent
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_zero0    <= i_clr || (!r_vld[i_raddr0] && !hit0);
            r_zero1    <= i_clr || (!r_vld[i_raddr1] && !hit1);
            r_use_byp0 <= hit0;
            r_use_byp1 <= hit1;
            r_byp      <= i_wdata;
        end
    end

    assign o_rdata0 = r_zero0 ? '0 : (r_use_byp0 ? r_byp : r_raw0);
    assign o_rdata1 = r_zero1 ? '0 : (r_use_byp1 ? r_byp : r_raw1);

endmodule

// ===== rtl/gema_pick.sv =====
// ----------------------------------------------------------------------------
// gema_pick
// least-filled free stage: min tree over the stage fill counts,
// lowest index wins ties
// ----------------------------------------------------------------------------
module gema_pick (
    input  gema_pkg::t_mask i_avail,
    input  gema_pkg::t_fill i_fill [gema_pkg::MAX_STAGES],
    output gema_pkg::t_pick o_pick
);
    import gema_pkg::*;

    localparam int LEVELS = $clog2(MAX_STAGES);
    localparam int NLEAF  = 1 << LEVELS;

    // key msb set marks a stage that is not free
    logic [FILL_W:0]  key [LEVELS+1][NLEAF];
    logic [STG_W-1:0] idx [LEVELS+1][NLEAF];

    always_comb begin
        for (int l = 0; l <= LEVELS; l++) begin
            for (int i = 0; i < NLEAF; i++) begin
                key[l][i] = '1;
                idx[l][i] = '0;
            end
        end
        for (int i = 0; i < MAX_STAGES; i++) begin
            key[0][i] = {~i_avail[i], i_fill[i]};
            idx[0][i] = STG_W'(i);
        end
        for (int l = 0; l < LEVELS; l++) begin
            for (int i = 0; i < (NLEAF >> (l + 1)); i++) begin
                if (key[l][2*i+1] < key[l][2*i]) begin
                    key[l+1][i] = key[l][2*i+1];
                    idx[l+1][i] = idx[l][2*i+1];
                end else begin
                    key[l+1][i] = key[l][2*i];
                    idx[l+1][i] = idx[l][2*i];
                end
            end
        end
        o_pick.idx = idx[LEVELS][0];
        o_pick.cnt = key[LEVELS][0][FILL_W-1:0];
    end

endmodule

// ===== rtl/greedy_edge_to_matching_assigner.sv =====
// ----------------------------------------------------------------------------
// greedy_edge_to_matching_assigner
// places score-sorted candidate edges greedily into edge-disjoint matchings
// ----------------------------------------------------------------------------
// usage
//   config port: i_cfg_we with i_cfg_index / i_cfg_data writes vertex_count
//   or stage_count; any write also clears the job (masks, fills, edge map,
//   total). write only while no item is in flight
//   input channel: i_in_valid / o_in_stall carry one candidate edge per item
//   output channel: o_out_valid / i_out_stall carry one result per edge,
//   in input order
//   latency: an item accepted at one edge is computed from the stage
//   register in the next cycle and shows on the output one edge later
//   throughput: one item per cycle; the read of the vertex masks and the
//   edge map at accept, and the min tree over the stage fills, each take
//   one cycle, and back-to-back items are served by bypassing the write
//   of the previous item into the read of the next
//   reset: counts return to 64 and the job state is empty at once through
//   row valid bits, so there is no clearing pass
//   stall: a stalled result holds in the output register; one more item
//   can wait in the stage register, after that o_in_stall rises
//   an item with i_last_edge set clears the job when its result is made
// ----------------------------------------------------------------------------
module greedy_edge_to_matching_assigner (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [gema_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [gema_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  logic [gema_pkg::VIN_W-1:0]      i_first_vertex,
    input  logic [gema_pkg::VIN_W-1:0]      i_second_vertex,
    input  logic                            i_last_edge,
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output logic [gema_pkg::STATUS_W-1:0]   o_status,
    output logic [gema_pkg::STG_W-1:0]      o_stage,
    output logic [gema_pkg::SLOT_W-1:0]     o_pair_slot,
    output logic [gema_pkg::VTX_W-1:0]      o_low_vertex,
    output logic [gema_pkg::VTX_W-1:0]      o_high_vertex,
    output logic                            o_all_stages_full,
    output logic                            o_end_of_job
);
    import gema_pkg::*;

    // configuration
    logic [VCNT_W-1:0]  r_vcount;
    logic [VCNT_W-1:0]  r_scount;
    logic               cfg_hit;

    // handshake
    logic               out_ready;
    logic               s1_ready;
    logic               in_accept;
    logic               s1_fire;

    // sorted input endpoints
    logic [VIN_W-1:0]   in_lo;
    logic [VIN_W-1:0]   in_hi;

    // stage register
    logic               r_s1_valid;
    logic [VIN_W-1:0]   r_lo;
    logic [VIN_W-1:0]   r_hi;
    logic               r_last;

    // job state
    t_fill              r_fill [MAX_STAGES];
    logic [TOTAL_W-1:0] r_total;
    logic [TOTAL_W-1:0] n_total;
    logic               job_clr;

    // edge map: one row per low vertex, one bit per high vertex
    t_row                    r_edge_mem [MAX_VERTICES];
    logic [MAX_VERTICES-1:0] r_edge_vld;
    t_row                    r_edge_raw;
    t_row                    r_edge_bdata;
    logic                    r_edge_zero;
    logic                    r_edge_byp;
    logic                    edge_hit;
    t_row                    edge_row;
    t_row                    edge_wdata;

    // mask reads: low bank holds stages taken as low endpoint, high bank
    // as high endpoint
    t_mask              l_lo;
    t_mask              l_hi;
    t_mask              h_lo;
    t_mask              h_hi;
    t_mask              stage_en;
    t_mask              avail;
    t_mask              pick_onehot;
    t_pick              pick;

    // classification
    logic               cfg_ok;
    logic [FILL_W-1:0]  half;
    logic [TOTAL_W-1:0] target;
    logic               bad_vtx;
    logic               is_repeat;
    t_status            status;
    logic               placed;
    logic               commit;
    logic               full;

    // output register
    logic               r_out_valid;
    t_status            r_status;
    logic [STG_W-1:0]   r_stage;
    logic [SLOT_W-1:0]  r_slot;
    logic [VTX_W-1:0]   r_low;
    logic [VTX_W-1:0]   r_high;
    logic               r_full;
    logic               r_eoj;

    // ---------------- configuration registers ----------------
    always_comb begin
        cfg_hit = 1'b0;
        if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_VERTEX_COUNT: cfg_hit = 1'b1;
                CFG_STAGE_COUNT:  cfg_hit = 1'b1;
                default:          cfg_hit = 1'b0;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vcount <= VCNT_W'(MAX_VERTICES);
            r_scount <= VCNT_W'(MAX_STAGES);
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_VERTEX_COUNT: r_vcount <= i_cfg_data;
                CFG_STAGE_COUNT:  r_scount <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // ---------------- handshake ----------------
    assign out_ready  = !r_out_valid || !i_out_stall;
    assign s1_ready   = !r_s1_valid || out_ready;
    assign in_accept  = i_in_valid && s1_ready;
    assign s1_fire    = r_s1_valid && out_ready;
    assign o_in_stall = !s1_ready;

    // sort endpoints at the port so the stores are read by low / high
    assign in_lo = (i_first_vertex < i_second_vertex) ? i_first_vertex : i_second_vertex;
    assign in_hi = (i_first_vertex < i_second_vertex) ? i_second_vertex : i_first_vertex;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (s1_ready) begin
            r_s1_valid <= in_accept;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_lo   <= in_lo;
            r_hi   <= in_hi;
            r_last <= i_last_edge;
        end
    end

    // ---------------- stores ----------------
    gema_mask_mem u_low_mem (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_clr    (job_clr),
        .i_we     (commit),
        .i_waddr  (r_lo[VTX_W-1:0]),
        .i_wdata  (l_lo | pick_onehot),
        .i_re     (in_accept),
        .i_raddr0 (in_lo[VTX_W-1:0]),
        .i_raddr1 (in_hi[VTX_W-1:0]),
        .o_rdata0 (l_lo),
        .o_rdata1 (l_hi)
    );

    gema_mask_mem u_high_mem (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_clr    (job_clr),
        .i_we     (commit),
        .i_waddr  (r_hi[VTX_W-1:0]),
        .i_wdata  (h_hi | pick_onehot),
        .i_re     (in_accept),
        .i_raddr0 (in_lo[VTX_W-1:0]),
        .i_raddr1 (in_hi[VTX_W-1:0]),
        .o_rdata0 (h_lo),
        .o_rdata1 (h_hi)
    );

    // edge map, same read scheme with a single read port
    assign edge_hit   = commit && (r_lo[VTX_W-1:0] == in_lo[VTX_W-1:0]);
    assign edge_wdata = edge_row | (t_row'(1) << r_hi[VTX_W-1:0]);

    always_ff @(posedge i_clk) begin
        if (commit) begin
            r_edge_mem[r_lo[VTX_W-1:0]] <= edge_wdata;
        end
        if (in_accept) begin
            r_edge_raw <= r_edge_mem[in_lo[VTX_W-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_edge_vld <= '0;
        end else if (job_clr) begin
            r_edge_vld <= '0;
        end else if (commit) begin
            r_edge_vld[r_lo[VTX_W-1:0]] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_edge_zero  <= job_clr || (!r_edge_vld[in_lo[VTX_W-1:0]] && !edge_hit);
            r_edge_byp   <= edge_hit;
            r_edge_bdata <= edge_wdata;
        end
    end

    assign edge_row = r_edge_zero ? '0 : (r_edge_byp ? r_edge_bdata : r_edge_raw);

    // ---------------- classification ----------------
    assign cfg_ok = (r_vcount >= VCNT_W'(2)) && !r_vcount[0]
                 && (r_vcount <= VCNT_W'(MAX_VERTICES))
                 && (r_scount >= VCNT_W'(1)) && (r_scount <= VCNT_W'(MAX_STAGES));

    assign half   = r_vcount[VCNT_W-1:1];
    assign target = TOTAL_W'(r_scount) * TOTAL_W'(half);

    // stages beyond stage_count are never free
    always_comb begin
        for (int s = 0; s < MAX_STAGES; s++) begin
            stage_en[s] = (r_scount > VCNT_W'(s));
        end
    end

    assign avail = stage_en & ~(l_lo | h_lo | l_hi | h_hi);

    gema_pick u_pick (
        .i_avail (avail),
        .i_fill  (r_fill),
        .o_pick  (pick)
    );

    assign bad_vtx   = (r_lo == r_hi) || (r_hi >= r_vcount);
    assign is_repeat = edge_row[r_hi[VTX_W-1:0]];

    // checking order: bad config, job done, bad vertex, repeat, no stage, stage full
    always_comb begin
        if (!cfg_ok) begin
            status = ST_BAD_CONFIG;
        end else if (r_total >= target) begin
            status = ST_JOB_DONE;
        end else if (bad_vtx) begin
            status = ST_BAD_VERTEX;
        end else if (is_repeat) begin
            status = ST_REPEAT;
        end else if (avail == '0) begin
            status = ST_NO_STAGE;
        end else if (pick.cnt >= half) begin
            status = ST_STAGE_FULL;
        end else begin
            status = ST_PLACED;
        end
    end

    assign placed      = (status == ST_PLACED);
    assign commit      = s1_fire && placed;
    assign pick_onehot = t_mask'(1) << pick.idx;
    assign n_total     = r_total + TOTAL_W'(placed);
    assign full        = cfg_ok && (n_total == target);
    assign job_clr     = cfg_hit || (s1_fire && r_last);

    // ---------------- job counters ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_total <= '0;
            for (int s = 0; s < MAX_STAGES; s++) begin
                r_fill[s] <= '0;
            end
        end else if (job_clr) begin
            r_total <= '0;
            for (int s = 0; s < MAX_STAGES; s++) begin
                r_fill[s] <= '0;
            end
        end else if (commit) begin
            r_total <= n_total;
            for (int s = 0; s < MAX_STAGES; s++) begin
                if (pick.idx == STG_W'(s)) begin
                    r_fill[s] <= r_fill[s] + FILL_W'(1);
                end
            end
        end
    end

    // ---------------- output register ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_ready) begin
            r_out_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_fire) begin
            r_status <= status;
            r_stage  <= placed ? pick.idx : '0;
            r_slot   <= placed ? pick.cnt[SLOT_W-1:0] : '0;
            r_low    <= placed ? r_lo[VTX_W-1:0] : '0;
            r_high   <= placed ? r_hi[VTX_W-1:0] : '0;
            r_full   <= full;
            r_eoj    <= r_last;
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_status          = r_status;
    assign o_stage           = r_stage;
    assign o_pair_slot       = r_slot;
    assign o_low_vertex      = r_low;
    assign o_high_vertex     = r_high;
    assign o_all_stages_full = r_full;
    assign o_end_of_job      = r_eoj;

endmodule

// ===== test/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// checks the greedy edge to matching assigner against a cycle-free predictor:
// directed edges at the field extremes and on every status but stage full, invalid register
// settings, a long output hold-off, then random jobs over many sizes with
// random gaps, or none, on both channels
// ----------------------------------------------------------------------------
module testbench;

    timeunit 1ns;
    timeprecision 1ps;

    import gema_pkg::*;

    localparam int HOLD_CYCLES   = 200;     // long receiver hold-off
    localparam int DRAIN_LIMIT   = 5000;    // cycles allowed to empty at the end
    localparam int MAX_REPORTED  = 10;

    // one expected result item, fields at the block's widths
    typedef struct packed {
        t_status            status;
        logic [STG_W-1:0]   stage;
        logic [SLOT_W-1:0]  slot;
        logic [VTX_W-1:0]   lo;
        logic [VTX_W-1:0]   hi;
        logic               full;
        logic               eoj;
    } t_placement;

    // ------------------------------------------------------------------------
    // dut signals; the driven inputs are known from time zero
    // ------------------------------------------------------------------------
    logic                   i_clk           = 1'b0;
    logic                   i_rst_n         = 1'b0;
    logic                   cfg_we          = 1'b0;
    logic [CFG_IDX_W-1:0]   cfg_index       = '0;
    logic [CFG_DATA_W-1:0]  cfg_data        = '0;
    logic                   in_valid        = 1'b0;
    logic                   o_in_stall;
    logic [VIN_W-1:0]       first_vertex    = '0;
    logic [VIN_W-1:0]       second_vertex   = '0;
    logic                   last_edge       = 1'b0;
    logic                   o_out_valid;
    logic                   out_stall       = 1'b0;
    logic [STATUS_W-1:0]    o_status;
    logic [STG_W-1:0]       o_stage;
    logic [SLOT_W-1:0]      o_pair_slot;
    logic [VTX_W-1:0]       o_low_vertex;
    logic [VTX_W-1:0]       o_high_vertex;
    logic                   o_all_stages_full;
    logic                   o_end_of_job;

    greedy_edge_to_matching_assigner u_top (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_we          (cfg_we),
        .i_cfg_index       (cfg_index),
        .i_cfg_data        (cfg_data),
        .i_in_valid        (in_valid),
        .o_in_stall        (o_in_stall),
        .i_first_vertex    (first_vertex),
        .i_second_vertex   (second_vertex),
        .i_last_edge       (last_edge),
        .o_out_valid       (o_out_valid),
        .i_out_stall       (out_stall),
        .o_status          (o_status),
        .o_stage           (o_stage),
        .o_pair_slot       (o_pair_slot),
        .o_low_vertex      (o_low_vertex),
        .o_high_vertex     (o_high_vertex),
        .o_all_stages_full (o_all_stages_full),
        .o_end_of_job      (o_end_of_job)
    );

    // 2 ns clock
    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // predictor state: a private copy of the job and of the two registers
    // ------------------------------------------------------------------------
    t_mask       vertex_used_stages [MAX_VERTICES];
    int          pairs_in_stage     [MAX_STAGES];
    bit          edge_placed        [MAX_VERTICES*MAX_VERTICES];
    int          pairs_total;
    int          vertex_count       = 64;
    int          stage_count        = 64;

    t_placement  predicted_placements [$];

    // bookkeeping for the closing summary
    int          errors             = 0;
    int          items_sent         = 0;
    int          results_checked    = 0;
    int          cfg_writes         = 0;
    int          input_stall_cycles = 0;
    int          status_seen [7];

    // idling controls shared by the sender and the receiver
    bit          steady             = 1'b0;  // no gaps, no stalls
    bit          hold_req           = 1'b0;  // ask the receiver for a long hold-off
    int          holds_done         = 0;

    function automatic void clear_job();
        for (int v = 0; v < MAX_VERTICES; v++) vertex_used_stages[v] = '0;
        for (int s = 0; s < MAX_STAGES; s++) pairs_in_stage[s] = 0;
        for (int e = 0; e < MAX_VERTICES*MAX_VERTICES; e++) edge_placed[e] = 1'b0;
        pairs_total = 0;
    endfunction

    // greedy placement of one candidate edge, updates the job state
    function automatic t_placement predict_placement(logic [VIN_W-1:0] va,
                                                     logic [VIN_W-1:0] vb,
                                                     logic last);
        t_placement r;
        int         a, b, t, half, target, best, best_cnt;
        t_mask      stage_limit, avail;
        r        = '0;
        r.status = ST_PLACED;
        r.eoj    = last;
        a        = va;
        b        = vb;
        half     = vertex_count / 2;
        target   = stage_count * half;
        if (vertex_count < 2 || vertex_count[0] || vertex_count > MAX_VERTICES ||
            stage_count < 1 || stage_count > MAX_STAGES) begin
            r.status = ST_BAD_CONFIG;
        end else begin
            if (pairs_total >= target) begin
                r.status = ST_JOB_DONE;
            end else if (a == b || a >= vertex_count || b >= vertex_count) begin
                r.status = ST_BAD_VERTEX;
            end else begin
                if (a > b) begin
                    t = a;
                    a = b;
                    b = t;
                end
                stage_limit = (stage_count >= MAX_STAGES) ? '1 :
                              ((t_mask'(1) << stage_count) - t_mask'(1));
                avail = stage_limit & ~(vertex_used_stages[a] | vertex_used_stages[b]);
                if (edge_placed[a*MAX_VERTICES + b]) begin
                    r.status = ST_REPEAT;
                end else if (avail == '0) begin
                    r.status = ST_NO_STAGE;
                end else begin
                    // least filled free stage, lowest index on ties
                    best     = 0;
                    best_cnt = half + 1;
                    for (int s = 0; s < stage_count; s++) begin
                        if (avail[s] && pairs_in_stage[s] < best_cnt) begin
                            best     = s;
                            best_cnt = pairs_in_stage[s];
                        end
                    end
                    if (best_cnt >= half) begin
                        r.status = ST_STAGE_FULL;
                    end else begin
                        r.stage = best[STG_W-1:0];
                        r.slot  = best_cnt[SLOT_W-1:0];
                        r.lo    = a[VTX_W-1:0];
                        r.hi    = b[VTX_W-1:0];
                        pairs_in_stage[best]++;
                        vertex_used_stages[a][best] = 1'b1;
                        vertex_used_stages[b][best] = 1'b1;
                        edge_placed[a*MAX_VERTICES + b] = 1'b1;
                        pairs_total++;
                    end
                end
            end
            r.full = (pairs_total == target);
        end
        // the last edge of a job empties the job whatever its status
        if (last) clear_job();
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // sender side
    // ------------------------------------------------------------------------
    function automatic int pick_gap();
        int r;
        if (steady) return 0;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 90) return $urandom_range(1, 3);
        if (r < 98) return $urandom_range(4, 8);
        return $urandom_range(15, 40);
    endfunction

    // offers one edge item and waits for it to be taken; valid stays high
    // after the accept so a following item can go out back to back
    task automatic send_edge(int a, int b, bit last);
        int         gap;
        t_placement expected;
        gap = pick_gap();
        if (gap > 0) begin
            in_valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        in_valid      = 1'b1;
        first_vertex  = a[VIN_W-1:0];
        second_vertex = b[VIN_W-1:0];
        last_edge     = last;
        forever begin
            @(posedge i_clk);
            if (!o_in_stall) break;
            input_stall_cycles++;
        end
        expected = predict_placement(first_vertex, second_vertex, last_edge);
        predicted_placements.insert(predicted_placements.size(), expected);
        items_sent++;
        @(negedge i_clk);
    endtask

    // register writes only go in once the block has nothing in flight
    task automatic write_config(t_cfg_reg idx, int value);
        in_valid = 1'b0;
        while (predicted_placements.size() != 0) @(negedge i_clk);
        repeat (3) @(negedge i_clk);
        cfg_we    = 1'b1;
        cfg_index = idx;
        cfg_data  = value[CFG_DATA_W-1:0];
        @(negedge i_clk);
        cfg_we    = 1'b0;
        if (idx == CFG_VERTEX_COUNT) vertex_count = value & 'h7f;
        else                         stage_count  = value & 'h7f;
        clear_job();
        cfg_writes++;
    endtask

    // ------------------------------------------------------------------------
    // receiver side: random stall runs, or one long counted hold-off
    // ------------------------------------------------------------------------
    initial begin : out_stall_gen
        int run, hold_left, r;
        run       = 0;
        hold_left = 0;
        forever begin
            @(negedge i_clk);
            if (hold_left > 0) begin
                hold_left--;
                out_stall = 1'b1;
            end else if (hold_req) begin
                hold_req  = 1'b0;
                hold_left = HOLD_CYCLES - 1;
                out_stall = 1'b1;
                holds_done++;
            end else if (steady) begin
                out_stall = 1'b0;
            end else if (run > 0) begin
                run--;
            end else begin
                r = $urandom_range(0, 99);
                if (r < 65) begin
                    out_stall = 1'b0;
                    run = $urandom_range(0, 6);
                end else if (r < 95) begin
                    out_stall = 1'b1;
                    run = $urandom_range(0, 2);
                end else begin
                    out_stall = 1'b1;
                    run = $urandom_range(10, 40);
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // result checker: each taken result against the oldest prediction
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_placement exp_r, act_r;
        if (i_rst_n && o_out_valid && !out_stall) begin
            act_r = {t_status'(o_status), o_stage, o_pair_slot, o_low_vertex,
                     o_high_vertex, o_all_stages_full, o_end_of_job};
            if (o_status < 7) status_seen[o_status]++;
            if (predicted_placements.size() == 0) begin
                errors++;
                if (errors <= MAX_REPORTED)
                    $display("tb: result item with no edge outstanding, status %0d",
                             o_status);
            end else begin
                exp_r = predicted_placements.pop_front();
                if (act_r.status !== exp_r.status || act_r.stage !== exp_r.stage ||
                    act_r.slot !== exp_r.slot || act_r.lo !== exp_r.lo ||
                    act_r.hi !== exp_r.hi || act_r.full !== exp_r.full ||
                    act_r.eoj !== exp_r.eoj) begin
                    errors++;
                    if (errors <= MAX_REPORTED)
                        $display({"tb: mismatch on result %0d: expected status %0d ",
                                  "stage %0d slot %0d lo %0d hi %0d full %b eoj %b, ",
                                  "got status %0d stage %0d slot %0d lo %0d hi %0d ",
                                  "full %b eoj %b"},
                                 results_checked, exp_r.status, exp_r.stage,
                                 exp_r.slot, exp_r.lo, exp_r.hi, exp_r.full,
                                 exp_r.eoj, o_status, o_stage, o_pair_slot,
                                 o_low_vertex, o_high_vertex, o_all_stages_full,
                                 o_end_of_job);
                end
            end
            results_checked++;
        end
    end

    // ------------------------------------------------------------------------
    // random jobs: mostly legal edges inside the vertex range, ending with
    // last_edge, plus repeats, self loops and raw 7 bit noise
    // ------------------------------------------------------------------------
    task automatic run_random_jobs(int n_items);
        int sent, r, vc, sc, jobs, len, a, b, last;
        int used_a [$];
        int used_b [$];
        sent = 0;
        while (sent < n_items) begin
            // new sizes: small ones fill up, a few large or invalid ones
            r = $urandom_range(0, 99);
            if (r < 70)      vc = 2 * $urandom_range(1, 6);
            else if (r < 88) vc = 2 * $urandom_range(7, 32);
            else if (r < 93) vc = 64;
            else             vc = $urandom_range(0, 127);
            r = $urandom_range(0, 99);
            if (r < 70)      sc = $urandom_range(1, 5);
            else if (r < 88) sc = $urandom_range(6, 64);
            else if (r < 94) sc = 64;
            else             sc = $urandom_range(0, 127);
            if ($urandom_range(0, 4) != 0) write_config(CFG_VERTEX_COUNT, vc);
            if ($urandom_range(0, 4) != 0) write_config(CFG_STAGE_COUNT, sc);
            jobs = $urandom_range(1, 3);
            for (int j = 0; j < jobs && sent < n_items; j++) begin
                // long enough at small sizes to run into the full cases
                len = (stage_count * vertex_count) / 2 + $urandom_range(0, 8);
                if (len < 1)  len = 1;
                if (len > 60) len = $urandom_range(20, 60);
                used_a.delete();
                used_b.delete();
                for (int k = 0; k < len; k++) begin
                    r = $urandom_range(0, 99);
                    if (r < 80 && vertex_count >= 2 && vertex_count <= MAX_VERTICES) begin
                        a = $urandom_range(0, vertex_count - 1);
                        b = (a + $urandom_range(1, vertex_count - 1)) % vertex_count;
                    end else if (r < 88 && used_a.size() != 0) begin
                        // repeat of an edge already offered, either order
                        a = $urandom_range(0, used_a.size() - 1);
                        if ($urandom_range(0, 1)) begin
                            b = used_a[a];
                            a = used_b[a];
                        end else begin
                            b = used_b[a];
                            a = used_a[a];
                        end
                    end else if (r < 94) begin
                        a = $urandom_range(0, 127);
                        b = a;
                    end else begin
                        a = $urandom_range(0, 127);
                        b = $urandom_range(0, 127);
                    end
                    used_a.insert(used_a.size(), a);
                    used_b.insert(used_b.size(), b);
                    last = (k == len - 1) || ($urandom_range(0, 99) == 0);
                    send_edge(a, b, last);
                    sent++;
                end
            end
        end
    endtask

    // ------------------------------------------------------------------------
    // test tasks
    // ------------------------------------------------------------------------

    // sizes after reset are 64 and 64: field extremes, repeat and bad vertex rejects
    task automatic test_reset_sizes();
        send_edge(0, 63, 0);     // placed, stage 0 slot 0
        send_edge(63, 0, 0);     // repeat, order swapped
        send_edge(5, 5, 0);      // self loop
        send_edge(127, 1, 0);    // endpoint far out of range
        send_edge(1, 64, 0);     // endpoint just out of range
        send_edge(63, 62, 0);    // stage 0 taken at 63, goes to stage 1
        send_edge(0, 1, 1);      // lands in stage 2, then the job clears
        send_edge(63, 0, 1);     // placed again in a fresh job
    endtask

    // smallest sizes: full stages, job complete, no common stage
    task automatic test_fill_limits();
        write_config(CFG_VERTEX_COUNT, 2);
        write_config(CFG_STAGE_COUNT, 1);
        send_edge(1, 0, 0);      // only pair, all stages full
        send_edge(0, 1, 0);      // job complete wins over repeat
        send_edge(0, 0, 1);      // job complete wins over self loop
        write_config(CFG_VERTEX_COUNT, 4);
        send_edge(0, 1, 0);
        send_edge(0, 2, 0);      // vertex 0 has no stage left
        send_edge(3, 2, 0);      // completes the only stage
        send_edge(1, 1, 1);
    endtask

    // invalid register values answer every edge with bad config
    task automatic test_bad_config();
        write_config(CFG_VERTEX_COUNT, 3);     // odd
        send_edge(0, 1, 0);
        write_config(CFG_VERTEX_COUNT, 0);
        send_edge(0, 1, 1);
        write_config(CFG_VERTEX_COUNT, 127);
        send_edge(2, 3, 0);
        write_config(CFG_VERTEX_COUNT, 66);    // even but above the maximum
        send_edge(2, 3, 0);
        write_config(CFG_VERTEX_COUNT, 64);
        write_config(CFG_STAGE_COUNT, 0);
        send_edge(0, 1, 0);
        write_config(CFG_STAGE_COUNT, 127);
        send_edge(0, 1, 1);
        write_config(CFG_STAGE_COUNT, 65);
        send_edge(0, 1, 0);
        write_config(CFG_STAGE_COUNT, 64);
        send_edge(0, 1, 0);                    // legal again
    endtask

    // receiver holds off while the sender keeps offering items, so the
    // output and stage registers fill and the input stall rises
    task automatic test_output_holdoff();
        write_config(CFG_VERTEX_COUNT, 16);
        write_config(CFG_STAGE_COUNT, 4);
        steady   = 1'b1;
        hold_req = 1'b1;
        for (int k = 0; k < 40; k++)
            send_edge($urandom_range(0, 15), $urandom_range(0, 15), k == 39);
        steady = 1'b0;
    endtask

    // random jobs with gaps on both sides
    task automatic test_random_jobs();
        run_random_jobs(450);
    endtask

    // random jobs at full rate, no gaps and no stalls
    task automatic test_steady_stream();
        steady = 1'b1;
        run_random_jobs(120);
        steady = 1'b0;
    endtask

    // ------------------------------------------------------------------------
    // sequence
    // ------------------------------------------------------------------------
    initial begin : main_seq
        int waited;
        for (int s = 0; s < 7; s++) status_seen[s] = 0;
        clear_job();
        repeat (6) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        test_reset_sizes();
        test_fill_limits();
        test_bad_config();
        test_output_holdoff();
        test_random_jobs();
        test_steady_stream();
        test_random_jobs();

        // drain, then wait on for stray results
        in_valid = 1'b0;
        waited = 0;
        while (predicted_placements.size() != 0 && waited < DRAIN_LIMIT) begin
            @(negedge i_clk);
            waited++;
        end
        repeat (10) @(negedge i_clk);
        if (predicted_placements.size() != 0) begin
            errors += predicted_placements.size();
            $display("tb: %0d edge results never arrived", predicted_placements.size());
        end

        $display("tb: %0d edges sent, %0d results checked, %0d register writes, %0d holds",
                 items_sent, results_checked, cfg_writes, holds_done);
        $display({"tb: placed %0d, bad vertex %0d, repeat %0d, no stage %0d, ",
                  "job done %0d, bad config %0d, input stalled %0d cycles, ",
                  "%0d mismatches"},
                 status_seen[ST_PLACED], status_seen[ST_BAD_VERTEX],
                 status_seen[ST_REPEAT], status_seen[ST_NO_STAGE],
                 status_seen[ST_JOB_DONE], status_seen[ST_BAD_CONFIG],
                 input_stall_cycles, errors);
        if (errors == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

    // overall limit, far beyond the slowest legal run
    initial begin : watchdog
        #2000000;
        $display("tb: failure");
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/gema_pkg.sv
rtl/gema_mask_mem.sv
rtl/gema_pick.sv
rtl/greedy_edge_to_matching_assigner.sv
test/testbench.sv
